// ===== hdl/flkc_pkg.sv =====
// Shared types, keyword table and class codes for the fault line keyword classifier.
// No dependencies; used by flkc_match and fault_line_keyword_classifier_unit.
package flkc_pkg;

   localparam int WinDepth   = 14;
   localparam int KwCount    = 16;
   localparam int KwMaxLen   = WinDepth + 1;
   localparam int GroupCount = 5;

   typedef logic [7:0]                char_type;
   typedef logic [1:0]                action_type;
   typedef logic [WinDepth-1:0][7:0]  window_type;
   typedef logic [GroupCount-1:0]     hits_type;
   typedef logic [8*KwMaxLen-1:0]     kw_text_type;
   typedef logic [3:0]                kw_len_type;
   typedef logic [2:0]                kw_group_type;

   localparam action_type ActByte = 2'd0;
   localparam action_type ActLast = 2'd1;
   localparam action_type ActEnd  = 2'd2;

   typedef enum logic [2:0] {
      CLS_NONE    = 3'd0,
      CLS_THERMAL = 3'd1,
      CLS_ENDSTOP = 3'd2,
      CLS_SERIAL  = 3'd3,
      CLS_COMMAND = 3'd4,
      CLS_FAULT   = 3'd5,
      CLS_UNKNOWN = 3'd6
   } class_type;

   // right aligned: last character sits in bits [7:0]
   localparam kw_text_type KW_TEXT [KwCount] = '{
      "thermal", "temp", "heater",
      "endstop", "homing failed", "home failed",
      "serial", "line number", "checksum", "resend",
      "unknown command", "bad command",
      "error:", "fault", "halted", "!!"
   };

   localparam kw_len_type KW_LEN [KwCount] = '{
      4'd7, 4'd4, 4'd6,
      4'd7, 4'd13, 4'd11,
      4'd6, 4'd11, 4'd8, 4'd6,
      4'd15, 4'd11,
      4'd6, 4'd5, 4'd6, 4'd2
   };

   localparam kw_group_type KW_GROUP [KwCount] = '{
      3'd0, 3'd0, 3'd0,
      3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2,
      3'd3, 3'd3,
      3'd4, 3'd4, 3'd4, 3'd4
   };

   function automatic char_type fold_case(input char_type c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'd32;
      end
      return c;
   endfunction

   function automatic class_type line_class(input logic nonempty, input hits_type hits);
      if (!nonempty) begin
         return CLS_NONE;
      end
      if (hits[0]) return CLS_THERMAL;
      if (hits[1]) return CLS_ENDSTOP;
      if (hits[2]) return CLS_SERIAL;
      if (hits[3]) return CLS_COMMAND;
      if (hits[4]) return CLS_FAULT;
      return CLS_UNKNOWN;
   endfunction

endpackage

// ===== hdl/flkc_match.sv =====
// Parallel keyword compare of the newest byte and the window of earlier bytes.
// Depends on flkc_pkg for the keyword table and the case fold.
module flkc_match (
   input  flkc_pkg::char_type   cur_char,
   input  flkc_pkg::window_type window,
   output flkc_pkg::hits_type   hits
);
   import flkc_pkg::*;

   char_type folded [KwMaxLen];
   logic     kw_hit [KwCount];

   always_comb begin
      folded[0] = fold_case(cur_char);
      for (int i = 1; i < KwMaxLen; i++) begin
         folded[i] = fold_case(window[i-1]);
      end
   end

   always_comb begin
      for (int k = 0; k < KwCount; k++) begin
         kw_hit[k] = 1'b1;
         for (int j = 0; j < KwMaxLen; j++) begin
            if (j < int'(KW_LEN[k]) && folded[j] != KW_TEXT[k][8*j +: 8]) begin
               kw_hit[k] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      hits = '0;
      for (int k = 0; k < KwCount; k++) begin
         if (kw_hit[k]) begin
            hits[KW_GROUP[k]] = 1'b1;
         end
      end
   end

endmodule

// ===== hdl/fault_line_keyword_classifier_unit.sv =====
// Top level of the fault line keyword classifier: request register, window state, result register.
// Depends on flkc_pkg and flkc_match.
//
//  channel  ports                             direction  meaning
//  req      req_valid/ready, char_code,action  in         one byte or line end
//  rsp      rsp_valid/ready, error_class       out        class of a finished line
//
// One request per cycle while req_ready is high; a line end's class goes to the result register.
// The keyword compare of the newest byte against the 14-byte window fills the one
// stage between the request register and the result register.
// Reset clears the window, hit flags and all valid flags.
// A waiting result stalls only a request that ends a line; byte requests keep flowing.
module fault_line_keyword_classifier_unit (
   input  logic                clock,
   input  logic                reset,
   input  flkc_pkg::char_type   req_char_code,
   input  flkc_pkg::action_type req_action,
   input  logic                req_valid,
   output logic                req_ready,
   output logic [2:0]          rsp_error_class,
   output logic                rsp_valid,
   input  logic                rsp_ready
);
   import flkc_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   char_type   s1_char_ff;
   action_type s1_action_ff;

   window_type window_ff, window_in;
   hits_type   hits_ff, hits_in;
   logic       nonempty_ff, nonempty_in;

   logic       rsp_valid_ff, rsp_valid_in;
   class_type  rsp_class_ff, rsp_class_in;

   hits_type   match_hits;
   logic       s1_emits, s1_take;

   flkc_match u_match (
      .cur_char (s1_char_ff),
      .window   (window_ff),
      .hits     (match_hits)
   );

   assign s1_emits  = s1_action_ff inside {ActLast, ActEnd};
   assign s1_take   = s1_valid_ff && (!s1_emits || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_take;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_error_class = rsp_class_ff;

   always_comb begin
      s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
      window_in    = window_ff;
      hits_in      = hits_ff;
      nonempty_in  = nonempty_ff;
      rsp_class_in = rsp_class_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s1_take) begin
         case (s1_action_ff)
            ActByte: begin
               window_in   = {window_ff[WinDepth-2:0], s1_char_ff};
               hits_in     = hits_ff | match_hits;
               nonempty_in = 1'b1;
            end
            ActLast: begin
               rsp_class_in = line_class(1'b1, hits_ff | match_hits);
               rsp_valid_in = 1'b1;
               window_in    = '0;
               hits_in      = '0;
               nonempty_in  = 1'b0;
            end
            ActEnd: begin
               rsp_class_in = line_class(nonempty_ff, hits_ff);
               rsp_valid_in = 1'b1;
               window_in    = '0;
               hits_in      = '0;
               nonempty_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= '0;
         hits_ff      <= '0;
         nonempty_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
         hits_ff      <= hits_in;
         nonempty_ff  <= nonempty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff   <= req_char_code;
         s1_action_ff <= req_action;
      end
      rsp_class_ff <= rsp_class_in;
   end

endmodule
